@@ rtl/core/wrap_flow_layout_defines.svh @@
// Assertion macros shared by the wrap flow layout RTL.
`ifndef WRAP_FLOW_LAYOUT_DEFINES_SVH
`define WRAP_FLOW_LAYOUT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define WFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Plain condition that must hold at every clock edge outside reset.
`define WFL_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

@@ rtl/core/wfl_pkg.sv @@
// Shared constants and types of the wrap flow layout block.
package wfl_pkg;

	// Coordinate width, unsigned fixed point 12.4
	localparam int COORD_BITS_DEF = 16;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ITEM_GAP_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITEM_GAP_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT   = 3'd6;

	// Per-request flags carried alongside the box sizes
	typedef struct packed {
		logic visible;
		logic last;
	} box_flags_t;

	localparam int FLAGS_W = $bits(box_flags_t);

endpackage

@@ rtl/core/wfl_front.sv @@
// Front end: takes box requests and sorts their sizes into along-line and across-line terms.
module wfl_front import wfl_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  vertical_mode,
	input  logic                  box_valid,
	output logic                  box_stall,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	input  logic                  box_visible,
	input  logic                  box_last,
	input  logic                  q_full,
	output logic                  push,
	output logic [COORD_BITS-1:0] len,
	output logic [COORD_BITS-1:0] thick,
	output box_flags_t            flags
);

	// Hold the sender off while the queue has no room
	assign box_stall = q_full;
	assign push      = box_valid & ~q_full;

	// Along-line length and line thickness; hidden boxes carry no size
	always_comb begin
		if (!box_visible) begin
			len   = '0;
			thick = '0;
		end else if (vertical_mode) begin
			len   = box_height;
			thick = box_width;
		end else begin
			len   = box_width;
			thick = box_height;
		end
		flags.visible = box_visible;
		flags.last    = box_last;
	end

endmodule

@@ rtl/core/wfl_queue.sv @@
// Short request queue between the front end and the placement back end.
`include "wrap_flow_layout_defines.svh"

module wfl_queue import wfl_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);
	assign rdata     = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`WFL_ALWAYS(a_q_count_bound, count_q <= CNT_FULL, "queue count beyond depth")
	`WFL_ASSERT(a_q_no_underrun, pop |-> count_q != '0, "pop from empty queue")
	`WFL_ASSERT(a_q_fill, (push && !pop) |=> count_q == $past(count_q) + 1'b1, "queue fill miscount")

endmodule

@@ rtl/core/wfl_back.sv @@
// Back end: line state update, then positions and extents into the result register.
`include "wrap_flow_layout_defines.svh"

module wfl_back import wfl_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  vertical_mode,
	input  logic [COORD_BITS-1:0] item_gap_x,
	input  logic [COORD_BITS-1:0] item_gap_y,
	input  logic [COORD_BITS-1:0] area_left,
	input  logic [COORD_BITS-1:0] area_top,
	input  logic [COORD_BITS-1:0] area_width,
	input  logic [COORD_BITS-1:0] area_height,
	// queue head
	input  logic                  q_valid,
	input  logic [COORD_BITS-1:0] q_len,
	input  logic [COORD_BITS-1:0] q_thick,
	input  box_flags_t            q_flags,
	output logic                  pop,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [COORD_BITS-1:0] place_x,
	output logic [COORD_BITS-1:0] place_y,
	output logic                  placed,
	output logic [COORD_BITS-1:0] extent_width,
	output logic [COORD_BITS-1:0] extent_height,
	output logic                  pass_done,
	output logic                  saturated
);

	localparam int CB = COORD_BITS;

	// Saturating add: {clip, value}
	function automatic logic [CB:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[CB] ? {1'b1, {CB{1'b1}}} : s;
	endfunction

	function automatic logic [CB-1:0] umax(input logic [CB-1:0] a, input logic [CB-1:0] b);
		umax = (a > b) ? a : b;
	endfunction

	// Line state
	logic [CB-1:0] line_used_q;
	logic [CB-1:0] line_thickness_q;
	logic [CB-1:0] closed_lines_span_q;
	logic [CB-1:0] longest_line_q;
	logic          line_has_items_q;
	logic          clip_seen_q;

	// Stage 1 registers
	logic          valid_s1;
	box_flags_t    flags_s1;
	logic [CB-1:0] offset_s1;
	logic [CB-1:0] used_s1;
	logic [CB-1:0] span_s1;
	logic [CB-1:0] thick_s1;
	logic [CB-1:0] longest_s1;
	logic          clip_s1;

	// Result registers
	logic          res_valid_q;
	logic [CB-1:0] place_x_q;
	logic [CB-1:0] place_y_q;
	logic          placed_q;
	logic [CB-1:0] extent_width_q;
	logic [CB-1:0] extent_height_q;
	logic          pass_done_q;
	logic          saturated_q;

	logic out_free;
	logic s1_move;

	assign out_free = ~res_valid_q | ~res_stall;
	assign s1_move  = ~valid_s1 | out_free;
	assign pop      = q_valid & s1_move;

	// Stage 1: wrap decision and new line state
	logic [CB-1:0] limit;
	logic [CB-1:0] gap_along;
	logic [CB-1:0] gap_across;
	logic          wrap;
	logic [CB:0]   span_a;
	logic [CB:0]   span_b;
	logic [CB:0]   used_gap;
	logic [CB-1:0] offset_n;
	logic [CB:0]   used_n;
	logic [CB-1:0] span_n;
	logic [CB-1:0] thick_n;
	logic [CB-1:0] longest_n;
	logic          clip_n;

	always_comb begin
		limit      = vertical_mode ? area_height : area_width;
		gap_along  = vertical_mode ? item_gap_y : item_gap_x;
		gap_across = vertical_mode ? item_gap_x : item_gap_y;
		// exact compare, no clipping
		wrap = q_flags.visible &&
			(({1'b0, line_used_q} + {1'b0, q_len}) > {1'b0, limit});
		span_a   = sat_add(closed_lines_span_q, line_thickness_q);
		span_b   = line_has_items_q ? sat_add(span_a[CB-1:0], gap_across) : span_a;
		used_gap = (line_used_q != '0) ? sat_add(line_used_q, gap_along) : {1'b0, line_used_q};
		offset_n = wrap ? '0 : used_gap[CB-1:0];
		used_n   = sat_add(offset_n, q_len);
		if (q_flags.visible) begin
			span_n    = wrap ? span_b[CB-1:0] : closed_lines_span_q;
			thick_n   = umax(wrap ? '0 : line_thickness_q, q_thick);
			longest_n = wrap ? umax(longest_line_q, line_used_q) : longest_line_q;
			clip_n    = used_n[CB] | (wrap ? (span_a[CB] | span_b[CB]) : used_gap[CB]);
		end else begin
			span_n    = closed_lines_span_q;
			thick_n   = line_thickness_q;
			longest_n = longest_line_q;
			clip_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_used_q         <= '0;
			line_thickness_q    <= '0;
			closed_lines_span_q <= '0;
			longest_line_q      <= '0;
			line_has_items_q    <= 1'b0;
			valid_s1            <= 1'b0;
		end else begin
			if (s1_move) begin
				valid_s1 <= pop;
			end
			if (pop) begin
				if (q_flags.last) begin
					line_used_q         <= '0;
					line_thickness_q    <= '0;
					closed_lines_span_q <= '0;
					longest_line_q      <= '0;
					line_has_items_q    <= 1'b0;
				end else if (q_flags.visible) begin
					line_used_q         <= used_n[CB-1:0];
					line_thickness_q    <= thick_n;
					closed_lines_span_q <= span_n;
					longest_line_q      <= longest_n;
					line_has_items_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			flags_s1   <= q_flags;
			offset_s1  <= offset_n;
			used_s1    <= q_flags.visible ? used_n[CB-1:0] : line_used_q;
			span_s1    <= span_n;
			thick_s1   <= thick_n;
			longest_s1 <= longest_n;
			clip_s1    <= clip_n;
		end
	end

	// Stage 2: positions, extents and the sticky clip flag
	logic [CB:0]   along_pos;
	logic [CB:0]   across_pos;
	logic [CB:0]   across_ext;
	logic [CB-1:0] along_ext;
	logic          clip_item;
	logic          seen_n;

	always_comb begin
		along_pos  = sat_add(vertical_mode ? area_top : area_left, offset_s1);
		across_pos = sat_add(vertical_mode ? area_left : area_top, span_s1);
		across_ext = sat_add(span_s1, thick_s1);
		along_ext  = umax(longest_s1, used_s1);
		clip_item  = clip_s1 | across_ext[CB] |
			(flags_s1.visible & (along_pos[CB] | across_pos[CB]));
		seen_n     = clip_seen_q | clip_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			clip_seen_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				clip_seen_q <= flags_s1.last ? 1'b0 : seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			if (!flags_s1.visible) begin
				place_x_q <= '0;
				place_y_q <= '0;
			end else if (vertical_mode) begin
				place_x_q <= across_pos[CB-1:0];
				place_y_q <= along_pos[CB-1:0];
			end else begin
				place_x_q <= along_pos[CB-1:0];
				place_y_q <= across_pos[CB-1:0];
			end
			extent_width_q  <= vertical_mode ? across_ext[CB-1:0] : along_ext;
			extent_height_q <= vertical_mode ? along_ext : across_ext[CB-1:0];
			placed_q        <= flags_s1.visible;
			pass_done_q     <= flags_s1.last;
			saturated_q     <= seen_n;
		end
	end

	assign res_valid     = res_valid_q;
	assign place_x       = place_x_q;
	assign place_y       = place_y_q;
	assign placed        = placed_q;
	assign extent_width  = extent_width_q;
	assign extent_height = extent_height_q;
	assign pass_done     = pass_done_q;
	assign saturated     = saturated_q;

	`WFL_ASSERT(a_s1_hold, (valid_s1 && !out_free) |=> valid_s1 && $stable(used_s1), "stage 1 lost a request under stall")
	`WFL_ASSERT(a_pass_clear, (pop && q_flags.last) |=> line_used_q == '0 && !line_has_items_q, "line state not cleared after last box")
	`WFL_ASSERT(a_hidden_origin, (res_valid_q && !placed_q) |-> place_x_q == '0 && place_y_q == '0, "hidden box given a position")

endmodule

@@ rtl/core/wrap_flow_layout.sv @@
// Wrap flow layout top level: configuration registers, front end, queue and back end.
// Greedy next-fit wrap layout of a box stream, one box per clock sustained while the result
// channel does not stall. An accepted box request is written into the queue (two entries by
// default), is popped from it into the line state update and the stage 1 registers, and its
// result is then registered in the output register. The line state loop in the back end
// (wrap compare, gap add and length add on the current line) limits the rate to one box per
// cycle. A stalled result does not stop acceptance until the queue fills.
// Configuration writes are always taken (cfg_ready is tied high); write only between passes.
// All coordinates are unsigned fixed point 12.4 by default and saturate, with a sticky flag.
`include "wrap_flow_layout_defines.svh"

module wrap_flow_layout import wfl_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	// box requests
	input  logic                  box_valid,
	output logic                  box_stall,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	input  logic                  box_visible,
	input  logic                  box_last,
	// placement results
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [COORD_BITS-1:0] place_x,
	output logic [COORD_BITS-1:0] place_y,
	output logic                  placed,
	output logic [COORD_BITS-1:0] extent_width,
	output logic [COORD_BITS-1:0] extent_height,
	output logic                  pass_done,
	output logic                  saturated
);

	localparam int QW = 2 * COORD_BITS + FLAGS_W;

	logic                  vertical_mode_q;
	logic [COORD_BITS-1:0] item_gap_x_q;
	logic [COORD_BITS-1:0] item_gap_y_q;
	logic [COORD_BITS-1:0] area_left_q;
	logic [COORD_BITS-1:0] area_top_q;
	logic [COORD_BITS-1:0] area_width_q;
	logic [COORD_BITS-1:0] area_height_q;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertical_mode_q <= 1'b0;
			item_gap_x_q    <= '0;
			item_gap_y_q    <= '0;
			area_left_q     <= '0;
			area_top_q      <= '0;
			area_width_q    <= '1;
			area_height_q   <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTICAL_MODE: vertical_mode_q <= cfg_data[0];
				REG_ITEM_GAP_X:    item_gap_x_q    <= cfg_data;
				REG_ITEM_GAP_Y:    item_gap_y_q    <= cfg_data;
				REG_AREA_LEFT:     area_left_q     <= cfg_data;
				REG_AREA_TOP:      area_top_q      <= cfg_data;
				REG_AREA_WIDTH:    area_width_q    <= cfg_data;
				REG_AREA_HEIGHT:   area_height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end
	logic                  push;
	logic                  q_full;
	logic [COORD_BITS-1:0] f_len;
	logic [COORD_BITS-1:0] f_thick;
	box_flags_t            f_flags;

	wfl_front #(.COORD_BITS(COORD_BITS)) u_front (
		.vertical_mode (vertical_mode_q),
		.box_valid     (box_valid),
		.box_stall     (box_stall),
		.box_width     (box_width),
		.box_height    (box_height),
		.box_visible   (box_visible),
		.box_last      (box_last),
		.q_full        (q_full),
		.push          (push),
		.len           (f_len),
		.thick         (f_thick),
		.flags         (f_flags)
	);

	// Queue between front and back
	logic [QW-1:0]         q_rdata;
	logic                  q_valid;
	logic                  pop;
	logic [COORD_BITS-1:0] q_len;
	logic [COORD_BITS-1:0] q_thick;
	box_flags_t            q_flags;

	wfl_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     ({f_flags, f_thick, f_len}),
		.pop       (pop),
		.rdata     (q_rdata),
		.not_empty (q_valid),
		.full      (q_full)
	);

	assign q_len   = q_rdata[COORD_BITS-1:0];
	assign q_thick = q_rdata[2*COORD_BITS-1:COORD_BITS];
	assign q_flags = box_flags_t'(q_rdata[QW-1:2*COORD_BITS]);

	// Back end
	wfl_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.vertical_mode (vertical_mode_q),
		.item_gap_x    (item_gap_x_q),
		.item_gap_y    (item_gap_y_q),
		.area_left     (area_left_q),
		.area_top      (area_top_q),
		.area_width    (area_width_q),
		.area_height   (area_height_q),
		.q_valid       (q_valid),
		.q_len         (q_len),
		.q_thick       (q_thick),
		.q_flags       (q_flags),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.place_x       (place_x),
		.place_y       (place_y),
		.placed        (placed),
		.extent_width  (extent_width),
		.extent_height (extent_height),
		.pass_done     (pass_done),
		.saturated     (saturated)
	);

	`WFL_ASSERT(a_full_stalls, q_full |-> box_stall, "request taken while queue full")
	`WFL_ASSERT(a_hidden_unplaced, (res_valid && !placed) |-> place_x == '0, "hidden box placed")
	`WFL_ASSERT(a_cfg_stable, !(cfg_valid && cfg_ready) |=> $stable(area_width_q) && $stable(vertical_mode_q), "config changed without write")

endmodule
